// File: rtl/bbe_pkg.sv
// Shared types and constants for the Bernstein basis evaluator.
// Used by every module in the rtl folder; depends on nothing else.
`default_nettype none

package bbe_pkg;

   localparam int MAX_POINTS_DEF = 8;

   localparam int LIMB_W     = 32;
   localparam int FACT_W     = 17;
   localparam int CARRY_W    = 17;
   localparam int PROD_W     = LIMB_W + CARRY_W;
   localparam int IDX_W      = 4;
   localparam int BINOM_W    = 10;
   localparam int OUT_DEPTH  = 8;
   localparam int T_W        = 20;
   localparam int VALUE_W    = 17;
   localparam int OUT_IDX_W  = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [FACT_W-1:0] ONE_Q16     = 17'h10000;
   localparam logic [IDX_W-1:0]  COUNT_RESET = 4'd4;
   localparam logic [IDX_W-1:0]  COUNT_MIN   = 4'd2;

   // Register index codes (byte address bit 2 selects the register).
   localparam logic REG_POINT_COUNT = 1'b0;

   typedef struct packed {
      logic                valid;
      logic                first;
      logic                last;
      logic [LIMB_W-1:0]   data;
      logic [FACT_W-1:0]   t;
      logic [FACT_W-1:0]   u;
      logic [IDX_W-1:0]    k;
      logic [IDX_W-1:0]    n;
      logic [IDX_W-1:0]    span;
   } limb_word_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] basis_index;
      logic [VALUE_W-1:0]   basis_value;
      logic [OUT_IDX_W-1:0] span_index;
      logic                 last_of_run;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: rtl/bbe_seq.sv
// Input stage and limb sequencer: clamps t, works out the span and issues
// one limb-serial product seed per basis value. Depends on bbe_pkg.
`default_nettype none

module bbe_seq #(
   parameter int MAX_POINTS = bbe_pkg::MAX_POINTS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [bbe_pkg::T_W-1:0]    req_param_t,
   input  wire logic [bbe_pkg::IDX_W-1:0]         point_count,
   input  wire logic                              rsp_take,
   output bbe_pkg::limb_word_type                 word_out
);

   localparam int LIMBS     = (MAX_POINTS + 1) / 2;
   localparam int LIMB_CW   = (LIMBS > 1) ? $clog2(LIMBS) : 1;
   localparam int CREDIT_W  = $clog2(bbe_pkg::OUT_DEPTH + 1);
   localparam int TAB_N     = MAX_POINTS * MAX_POINTS;
   localparam int TAB_IDX_W = $clog2(TAB_N);
   localparam logic [LIMB_CW-1:0]       LIMB_LAST = LIMB_CW'(LIMBS - 1);
   localparam logic [bbe_pkg::IDX_W-1:0] N_MAX    = bbe_pkg::IDX_W'(MAX_POINTS);
   localparam logic [CREDIT_W-1:0]      CREDIT_MAX = CREDIT_W'(bbe_pkg::OUT_DEPTH);

   function automatic logic [TAB_N*bbe_pkg::BINOM_W-1:0] binom_table();
      logic [bbe_pkg::BINOM_W-1:0]       row [MAX_POINTS];
      logic [TAB_N*bbe_pkg::BINOM_W-1:0] tab;
      int                                m;
      int                                j;
      tab = '0;
      for (j = 0; j < MAX_POINTS; j++) begin
         row[j] = '0;
      end
      row[0] = bbe_pkg::BINOM_W'(1);
      for (m = 0; m < MAX_POINTS; m++) begin
         for (j = m; j > 0; j--) begin
            row[j] = row[j] + row[j-1];
         end
         for (j = 0; j <= m; j++) begin
            tab[(m*MAX_POINTS + j)*bbe_pkg::BINOM_W +: bbe_pkg::BINOM_W] = row[j];
         end
      end
      return tab;
   endfunction

   localparam logic [TAB_N*bbe_pkg::BINOM_W-1:0] BINOM_TAB = binom_table();

   logic                              busy_ff, busy_in;
   logic [bbe_pkg::FACT_W-1:0]        t_ff, t_in;
   logic [bbe_pkg::FACT_W-1:0]        u_ff, u_in;
   logic [bbe_pkg::IDX_W-1:0]         n_ff, n_in;
   logic [bbe_pkg::IDX_W-1:0]         span_ff, span_in;
   logic [bbe_pkg::IDX_W-1:0]         k_ff, k_in;
   logic [LIMB_CW-1:0]                limb_ff, limb_in;
   logic [CREDIT_W-1:0]               credit_ff, credit_in;

   logic [bbe_pkg::IDX_W-1:0]         n_eff;
   logic [bbe_pkg::IDX_W-1:0]         n_eff_m1;
   logic                              t_neg;
   logic                              t_over;
   logic [bbe_pkg::FACT_W-1:0]        t_clamp;
   logic [bbe_pkg::FACT_W+bbe_pkg::IDX_W-1:0] span_prod;
   logic [bbe_pkg::IDX_W:0]           span_raw;
   logic [bbe_pkg::IDX_W-1:0]         span_c;
   logic                              credit_ok;
   logic                              issue;
   logic                              seed;
   logic                              limb_end;
   logic                              run_end;
   logic                              finish;
   logic                              accept;
   logic [TAB_IDX_W-1:0]              tab_idx;
   logic [bbe_pkg::BINOM_W-1:0]       binom;

   always_comb begin
      if (point_count < bbe_pkg::COUNT_MIN) begin
         n_eff = bbe_pkg::COUNT_MIN;
      end else if (point_count > N_MAX) begin
         n_eff = N_MAX;
      end else begin
         n_eff = point_count;
      end
      n_eff_m1 = n_eff - bbe_pkg::IDX_W'(1);
   end

   // Out-of-range t behaves exactly as t clamped to zero or one.
   assign t_neg  = req_param_t[bbe_pkg::T_W-1];
   assign t_over = !t_neg && (req_param_t[bbe_pkg::T_W-2:0] >
                              (bbe_pkg::T_W-1)'(bbe_pkg::ONE_Q16));

   always_comb begin
      if (t_neg) begin
         t_clamp = '0;
      end else if (t_over) begin
         t_clamp = bbe_pkg::ONE_Q16;
      end else begin
         t_clamp = req_param_t[bbe_pkg::FACT_W-1:0];
      end
      span_prod = {{bbe_pkg::IDX_W{1'b0}}, t_clamp} *
                  {{bbe_pkg::FACT_W{1'b0}}, n_eff};
      span_raw  = span_prod[bbe_pkg::FACT_W+bbe_pkg::IDX_W-1:16];
      if (span_raw > {1'b0, n_eff_m1}) begin
         span_c = n_eff_m1;
      end else begin
         span_c = span_raw[bbe_pkg::IDX_W-1:0];
      end
   end

   assign credit_ok = credit_ff < CREDIT_MAX;
   assign issue     = busy_ff && ((limb_ff != '0) || credit_ok);
   assign seed      = issue && (limb_ff == '0);
   assign limb_end  = limb_ff == LIMB_LAST;
   assign run_end   = k_ff == (n_ff - bbe_pkg::IDX_W'(1));
   assign finish    = issue && limb_end && run_end;
   assign req_stall = busy_ff && !finish;
   assign accept    = req_valid && !req_stall;

   assign tab_idx = TAB_IDX_W'(int'(n_ff - bbe_pkg::IDX_W'(1)) * MAX_POINTS + int'(k_ff));
   assign binom   = BINOM_TAB[tab_idx*bbe_pkg::BINOM_W +: bbe_pkg::BINOM_W];

   always_comb begin
      busy_in = busy_ff;
      t_in    = t_ff;
      u_in    = u_ff;
      n_in    = n_ff;
      span_in = span_ff;
      k_in    = k_ff;
      limb_in = limb_ff;
      if (issue) begin
         if (limb_end) begin
            limb_in = '0;
            k_in    = run_end ? '0 : k_ff + bbe_pkg::IDX_W'(1);
         end else begin
            limb_in = limb_ff + LIMB_CW'(1);
         end
      end
      if (finish) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
         t_in    = t_clamp;
         u_in    = bbe_pkg::ONE_Q16 - t_clamp;
         n_in    = n_eff;
         span_in = span_c;
         k_in    = '0;
         limb_in = '0;
      end
      credit_in = credit_ff + CREDIT_W'(seed) - CREDIT_W'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         k_ff      <= '0;
         limb_ff   <= '0;
         credit_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         k_ff      <= k_in;
         limb_ff   <= limb_in;
         credit_ff <= credit_in;
      end
      t_ff    <= t_in;
      u_ff    <= u_in;
      n_ff    <= n_in;
      span_ff <= span_in;
   end

   always_comb begin
      word_out.valid = issue;
      word_out.first = limb_ff == '0;
      word_out.last  = limb_end;
      word_out.data  = (limb_ff == '0) ? bbe_pkg::LIMB_W'(binom) : '0;
      word_out.t     = t_ff;
      word_out.u     = u_ff;
      word_out.k     = k_ff;
      word_out.n     = n_ff;
      word_out.span  = span_ff;
   end

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CREDIT_MAX)
      else $error("result buffer space over-reserved");

   a_seed_has_space: assert property (@(posedge clock) disable iff (reset)
      seed |-> credit_ok)
      else $error("basis value started without buffer space");

endmodule

`default_nettype wire

// File: rtl/bbe_cell.sv
// One multiplier cell of the chain: multiplies the passing limb stream by
// t, 1-t or one, carrying between limbs. Depends on bbe_pkg.
`default_nettype none

module bbe_cell #(
   parameter int CELL_IDX = 0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bbe_pkg::limb_word_type word_in,
   output bbe_pkg::limb_word_type      word_out
);

   localparam logic [bbe_pkg::IDX_W-1:0] POS  = bbe_pkg::IDX_W'(CELL_IDX);
   localparam logic [bbe_pkg::IDX_W-1:0] POS1 = bbe_pkg::IDX_W'(CELL_IDX + 1);

   bbe_pkg::limb_word_type       word_ff, word_in_c;
   logic [bbe_pkg::CARRY_W-1:0]  carry_ff, carry_in;
   logic [bbe_pkg::FACT_W-1:0]   factor;
   logic [bbe_pkg::CARRY_W-1:0]  carry_add;
   logic [bbe_pkg::PROD_W-1:0]   prod;

   always_comb begin
      if (POS < word_in.k) begin
         factor = word_in.t;
      end else if (POS1 < word_in.n) begin
         factor = word_in.u;
      end else begin
         factor = bbe_pkg::FACT_W'(1);
      end
      carry_add = word_in.first ? '0 : carry_ff;
      prod = {{bbe_pkg::CARRY_W{1'b0}}, word_in.data} *
             {{bbe_pkg::LIMB_W{1'b0}}, factor} +
             bbe_pkg::PROD_W'(carry_add);
      word_in_c      = word_in;
      word_in_c.data = prod[bbe_pkg::LIMB_W-1:0];
      carry_in       = word_in.valid ? prod[bbe_pkg::PROD_W-1:bbe_pkg::LIMB_W] : carry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else begin
         word_ff.valid <= word_in_c.valid;
      end
      word_ff.first <= word_in_c.first;
      word_ff.last  <= word_in_c.last;
      word_ff.data  <= word_in_c.data;
      word_ff.t     <= word_in_c.t;
      word_ff.u     <= word_in_c.u;
      word_ff.k     <= word_in_c.k;
      word_ff.n     <= word_in_c.n;
      word_ff.span  <= word_in_c.span;
      carry_ff      <= carry_in;
   end

   assign word_out = word_ff;

   a_no_carry_out: assert property (@(posedge clock) disable iff (reset)
      (word_in.valid && word_in.last) |->
         (prod[bbe_pkg::PROD_W-1:bbe_pkg::LIMB_W] == '0))
      else $error("product overflowed the limb stream");

endmodule

`default_nettype wire

// File: rtl/bbe_collect.sv
// Collector at the end of the chain: gathers the limbs of one product,
// rounds it to Q1.16 and forms the result word. Depends on bbe_pkg.
`default_nettype none

module bbe_collect #(
   parameter int MAX_POINTS = bbe_pkg::MAX_POINTS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bbe_pkg::limb_word_type word_in,
   output logic                        push,
   output bbe_pkg::rsp_word_type       push_data
);

   localparam int LIMBS  = (MAX_POINTS + 1) / 2;
   localparam int DATA_W = LIMBS * bbe_pkg::LIMB_W;

   logic [DATA_W-1:0]          acc_ff, acc_in;
   logic                       done_ff;
   logic [bbe_pkg::IDX_W-1:0]  k_ff;
   logic [bbe_pkg::IDX_W-1:0]  n_ff;
   logic [bbe_pkg::IDX_W-1:0]  span_ff;

   logic [bbe_pkg::IDX_W-1:0]  n_m2;
   logic [bbe_pkg::IDX_W+3:0]  sh_amt;
   logic [DATA_W-1:0]          sh;
   logic [DATA_W:0]            rbits;
   logic [bbe_pkg::VALUE_W:0]  val_r;
   logic                       hi_nz;
   logic                       sat;

   generate
      if (LIMBS > 1) begin : g_multi
         assign acc_in = {word_in.data, acc_ff[DATA_W-1:bbe_pkg::LIMB_W]};
      end else begin : g_single
         assign acc_in = word_in.data;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= word_in.valid && word_in.last;
      end
      if (word_in.valid) begin
         acc_ff <= acc_in;
      end
      if (word_in.valid && word_in.last) begin
         k_ff    <= word_in.k;
         n_ff    <= word_in.n;
         span_ff <= word_in.span;
      end
   end

   // The product carries 16*(n-1) fraction bits; keep 16 and round half up.
   always_comb begin
      n_m2   = n_ff - bbe_pkg::IDX_W'(2);
      sh_amt = {n_m2, 4'b0000};
      sh     = acc_ff >> sh_amt;
      rbits  = {acc_ff, 1'b0} >> sh_amt;
      hi_nz  = |sh[DATA_W-1:bbe_pkg::VALUE_W];
      val_r  = {1'b0, sh[bbe_pkg::VALUE_W-1:0]} + (bbe_pkg::VALUE_W+1)'(rbits[0]);
      sat    = hi_nz || (val_r > (bbe_pkg::VALUE_W+1)'(bbe_pkg::ONE_Q16));
   end

   assign push = done_ff;

   always_comb begin
      push_data.basis_index = k_ff[bbe_pkg::OUT_IDX_W-1:0];
      push_data.basis_value = sat ? bbe_pkg::ONE_Q16 : val_r[bbe_pkg::VALUE_W-1:0];
      push_data.span_index  = span_ff[bbe_pkg::OUT_IDX_W-1:0];
      push_data.last_of_run = k_ff == (n_ff - bbe_pkg::IDX_W'(1));
   end

endmodule

`default_nettype wire

// File: rtl/bbe_fifo.sv
// Result buffer between the chain and the result channel.
// Depends on bbe_pkg for the word type and depth.
`default_nettype none

module bbe_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire bbe_pkg::rsp_word_type push_data,
   input  wire logic                  pop,
   output logic                       out_valid,
   output bbe_pkg::rsp_word_type      out_data
);

   localparam int PTR_W = $clog2(bbe_pkg::OUT_DEPTH);
   localparam int CNT_W = $clog2(bbe_pkg::OUT_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(bbe_pkg::OUT_DEPTH);

   bbe_pkg::rsp_word_type  mem_ff [bbe_pkg::OUT_DEPTH];
   bbe_pkg::rsp_word_type  out_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [PTR_W-1:0]       wr_ff, wr_in;
   logic [PTR_W-1:0]       rd_ff, rd_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   load;
   logic                   from_mem;
   logic                   bypass;
   logic                   wr_en;

   // The output register is refilled from the store, or straight from the
   // incoming word when the store is empty.
   always_comb begin
      load         = !out_valid_ff || pop;
      from_mem     = load && (count_ff != '0);
      bypass       = load && (count_ff == '0) && push;
      wr_en        = push && !bypass;
      wr_in        = wr_en ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in        = from_mem ? rd_ff + PTR_W'(1) : rd_ff;
      count_in     = count_ff + CNT_W'(wr_en) - CNT_W'(from_mem);
      out_valid_in = load ? (from_mem || bypass) : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff        <= '0;
         rd_ff        <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      if (wr_en) begin
         mem_ff[wr_ff] <= push_data;
      end
      if (from_mem) begin
         out_ff <= mem_ff[rd_ff];
      end else if (bypass) begin
         out_ff <= push_data;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != FULL))
      else $error("result buffer overflow");

endmodule

`default_nettype wire

// File: rtl/bernstein_basis_eval.sv
// Top level of the Bernstein basis evaluator: register port, sequencer,
// chain of multiplier cells, collector and result buffer. Depends on bbe_pkg.
//
// Each word on the req channel carries one curve parameter t (signed Q3.16).
// For it the block returns n words on the rsp channel, k = 0 .. n-1, where n is
// point_count clamped to 2 .. MAX_POINTS; each word holds B(k) in unsigned
// Q1.16, the span index and a flag on the last word of the run.
// Every basis value is an exact product streamed through the cell chain in
// (MAX_POINTS+1)/2 limbs of 32 bits, one limb per cycle once it has started.
// A new t is taken in the cycle its predecessor's last limb leaves the
// sequencer. Results wait in an eight-word buffer. While the receiver
// stalls, the sequencer only starts a basis value when buffer space is
// reserved for it, so nothing is lost and req_stall stays high while the
// sequencer waits for space.
// Reset empties the chain and buffer and sets point_count to 4. point_count
// is written at byte address 0 and should change only while the block is idle.

`default_nettype none

module bernstein_basis_eval #(
   parameter int MAX_POINTS = bbe_pkg::MAX_POINTS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [bbe_pkg::T_W-1:0]      req_param_t,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [bbe_pkg::OUT_IDX_W-1:0]            rsp_basis_index,
   output logic [bbe_pkg::VALUE_W-1:0]              rsp_basis_value,
   output logic [bbe_pkg::OUT_IDX_W-1:0]            rsp_span_index,
   output logic                                     rsp_last_of_run,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [bbe_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [bbe_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [bbe_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                     csr_pready
);

   logic [bbe_pkg::IDX_W-1:0]  point_count_ff, point_count_in;
   logic                       csr_write;
   logic                       csr_sel_count;
   logic                       rsp_take;
   logic                       push;
   bbe_pkg::rsp_word_type      push_data;
   bbe_pkg::rsp_word_type      out_data;
   bbe_pkg::limb_word_type     chain [MAX_POINTS];

   assign csr_pready    = 1'b1;
   assign csr_sel_count = csr_paddr[2] == bbe_pkg::REG_POINT_COUNT;
   assign csr_write     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      point_count_in = point_count_ff;
      if (csr_write && csr_sel_count) begin
         point_count_in = csr_pwdata[bbe_pkg::IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= bbe_pkg::COUNT_RESET;
      end else begin
         point_count_ff <= point_count_in;
      end
   end

   assign csr_prdata = csr_sel_count ?
                       bbe_pkg::CSR_DATA_W'(point_count_ff) : '0;

   assign rsp_take = rsp_valid && !rsp_stall;

   bbe_seq #(
      .MAX_POINTS (MAX_POINTS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_param_t (req_param_t),
      .point_count (point_count_ff),
      .rsp_take    (rsp_take),
      .word_out    (chain[0])
   );

   generate
      for (genvar i = 0; i < MAX_POINTS - 1; i++) begin : g_cell
         bbe_cell #(
            .CELL_IDX (i)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .word_in  (chain[i]),
            .word_out (chain[i+1])
         );
      end
   endgenerate

   bbe_collect #(
      .MAX_POINTS (MAX_POINTS)
   ) u_collect (
      .clock     (clock),
      .reset     (reset),
      .word_in   (chain[MAX_POINTS-1]),
      .push      (push),
      .push_data (push_data)
   );

   bbe_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_take),
      .out_valid (rsp_valid),
      .out_data  (out_data)
   );

   assign rsp_basis_index = out_data.basis_index;
   assign rsp_basis_value = out_data.basis_value;
   assign rsp_span_index  = out_data.span_index;
   assign rsp_last_of_run = out_data.last_of_run;

endmodule

`default_nettype wire

// File: tb/basis_run_monitor.sv
// Watches the parameter and basis channels of the Bernstein basis evaluator,
// predicts every basis word from the accepted t values and compares them.
// Depends on bbe_pkg for widths, the result word type and the register code.
module basis_run_monitor
   import bbe_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic signed [T_W-1:0]         req_param_t,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [OUT_IDX_W-1:0]          rsp_basis_index,
   input  wire logic [VALUE_W-1:0]            rsp_basis_value,
   input  wire logic [OUT_IDX_W-1:0]          rsp_span_index,
   input  wire logic                          rsp_last_of_run,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]         csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]         csr_pwdata,
   input  wire logic                          csr_pready,
   output int                                 mismatch_count,
   output int                                 words_outstanding
);

   localparam logic [CSR_ADDR_W-1:0] POINT_COUNT_ADDR = {REG_POINT_COUNT, 2'b00};
   localparam int                    MAX_N            = MAX_POINTS_DEF;

   logic [IDX_W-1:0] point_count_q;
   rsp_word_type     basis_words_due[$];

   function automatic logic [VALUE_W-1:0] bernstein_q16(input int unsigned n,
                                                        input int unsigned k,
                                                        input logic [16:0] t);
      logic [191:0] acc;
      logic [16:0]  u;
      int unsigned  c;
      int unsigned  i;
      u = ONE_Q16 - t;
      c = 1;
      for (i = 0; i < k; i++)
         c = c * (n - 1 - i) / (i + 1);
      acc = 192'(c);
      for (i = 0; i < k; i++)
         acc = acc * t;
      for (i = k; i + 1 < n; i++)
         acc = acc * u;
      if (n > 2)
         acc = acc + (192'd1 << (16 * (n - 2) - 1));
      acc = acc >> (16 * (n - 2));
      if (acc > 192'(ONE_Q16))
         return ONE_Q16;
      return acc[VALUE_W-1:0];
   endfunction

   task automatic queue_basis_run(input logic signed [T_W-1:0] t);
      int unsigned  n;
      int unsigned  span;
      int unsigned  k;
      rsp_word_type w;
      n = point_count_q;
      if (n < COUNT_MIN)
         n = COUNT_MIN;
      if (n > MAX_N)
         n = MAX_N;
      if (t < 0)
         span = 0;
      else if (t > $signed({3'b000, ONE_Q16}))
         span = n - 1;
      else begin
         span = (int'(t) * n) >> 16;
         if (span > n - 1)
            span = n - 1;
      end
      for (k = 0; k < n; k++) begin
         w.basis_index = OUT_IDX_W'(k);
         w.span_index  = OUT_IDX_W'(span);
         w.last_of_run = (k == n - 1);
         if (t < 0)
            w.basis_value = (k == 0) ? ONE_Q16 : '0;
         else if (t > $signed({3'b000, ONE_Q16}))
            w.basis_value = (k == n - 1) ? ONE_Q16 : '0;
         else
            w.basis_value = bernstein_q16(n, k, t[16:0]);
         basis_words_due.push_back(w);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type due;
      if (reset) begin
         point_count_q = COUNT_RESET;
         basis_words_due.delete();
         mismatch_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == POINT_COUNT_ADDR)
            point_count_q = csr_pwdata[IDX_W-1:0];
         if (req_valid && !req_stall)
            queue_basis_run(req_param_t);
         if (rsp_valid && !rsp_stall) begin
            if (basis_words_due.size() == 0) begin
               $error("Unexpected basis word with basis_index %0d", rsp_basis_index);
               mismatch_count++;
            end else begin
               due = basis_words_due.pop_front();
               if (rsp_basis_index !== due.basis_index) begin
                  $error("basis_index: expected %0d, got %0d",
                         due.basis_index, rsp_basis_index);
                  mismatch_count++;
               end
               if (rsp_basis_value !== due.basis_value) begin
                  $error("basis_value: expected %0d, got %0d",
                         due.basis_value, rsp_basis_value);
                  mismatch_count++;
               end
               if (rsp_span_index !== due.span_index) begin
                  $error("span_index: expected %0d, got %0d",
                         due.span_index, rsp_span_index);
                  mismatch_count++;
               end
               if (rsp_last_of_run !== due.last_of_run) begin
                  $error("last_of_run: expected %0d, got %0d",
                         due.last_of_run, rsp_last_of_run);
                  mismatch_count++;
               end
            end
         end
      end
      words_outstanding = basis_words_due.size();
   end

endmodule

// File: tb/bernstein_basis_eval_tb.sv
// Top of the Bernstein basis evaluator testbench: drives t values and the
// point_count register, idles both channels and gives the verdict.
// Depends on bbe_pkg, bernstein_basis_eval and basis_run_monitor.
module bernstein_basis_eval_tb;
   import bbe_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] POINT_COUNT_ADDR = {REG_POINT_COUNT, 2'b00};
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 60;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [T_W-1:0]     req_param_t;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [OUT_IDX_W-1:0]      rsp_basis_index;
   logic [VALUE_W-1:0]        rsp_basis_value;
   logic [OUT_IDX_W-1:0]      rsp_span_index;
   logic                      rsp_last_of_run;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_W-1:0]     csr_paddr;
   logic [CSR_DATA_W-1:0]     csr_pwdata;
   logic [CSR_DATA_W-1:0]     csr_prdata;
   logic                      csr_pready;

   int   mismatch_count;
   int   words_outstanding;
   int   sender_idle_pct;
   int   receiver_stall_pct;
   logic hold_request;
   int   quiet_cycles;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   bernstein_basis_eval uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_param_t     (req_param_t),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_basis_index (rsp_basis_index),
      .rsp_basis_value (rsp_basis_value),
      .rsp_span_index  (rsp_span_index),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   basis_run_monitor monitor (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_param_t       (req_param_t),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_basis_index   (rsp_basis_index),
      .rsp_basis_value   (rsp_basis_value),
      .rsp_span_index    (rsp_span_index),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .mismatch_count    (mismatch_count),
      .words_outstanding (words_outstanding)
   );

   // The receiver either stalls at random or, on request, holds off for a long stretch.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic offer_param(input logic signed [T_W-1:0] t);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_param_t <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (words_outstanding != 0) @(negedge clock);
   endtask

   task automatic write_point_count(input logic [IDX_W-1:0] value);
      drain_results();
      repeat (4) @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= POINT_COUNT_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic signed [T_W-1:0] random_param();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 68)
         return T_W'($urandom_range(65536));
      else if (pick < 78)
         case ($urandom_range(4))
            0: return '0;
            1: return T_W'(1);
            2: return T_W'(65535);
            3: return T_W'(65536);
            default: return T_W'(32768);
         endcase
      else if (pick < 89)
         return T_W'(32'd1048576 - $urandom_range(524288, 1));
      else
         return T_W'($urandom_range(524287, 65537));
   endfunction

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_param_t        = '0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_request       = 1'b0;
      quiet_cycles       = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The reset count of four, then the smallest and largest counts and the
      // out-of-range counts that are clamped.
      offer_param(T_W'(0));
      offer_param(T_W'(65536));
      offer_param(T_W'(32768));
      offer_param(T_W'(1));
      offer_param(T_W'(65535));
      offer_param(T_W'(-1));
      offer_param(T_W'(65537));
      offer_param(T_W'(-524288));
      offer_param(T_W'(524287));
      write_point_count(4'd2);
      offer_param(T_W'(0));
      offer_param(T_W'(32768));
      offer_param(T_W'(65536));
      offer_param(T_W'(-1));
      offer_param(T_W'(65537));
      write_point_count(4'd8);
      offer_param(T_W'(0));
      offer_param(T_W'(1));
      offer_param(T_W'(32768));
      offer_param(T_W'(65535));
      offer_param(T_W'(65536));
      offer_param(T_W'(524287));
      write_point_count(4'd0);
      offer_param(T_W'(16384));
      write_point_count(4'd15);
      offer_param(T_W'(49152));
      write_point_count(4'd1);
      offer_param(T_W'(40000));
      write_point_count(4'd9);
      offer_param(T_W'(20000));

      for (int segment = 0; segment < 8; segment++) begin
         case (segment)
            0: write_point_count(4'd3);
            1: write_point_count(4'd8);
            2: write_point_count(4'd2);
            3: write_point_count(IDX_W'($urandom_range(15)));
            4: write_point_count(4'd5);
            5: write_point_count(4'd7);
            6: write_point_count(4'd6);
            default: write_point_count(IDX_W'($urandom_range(8, 2)));
         endcase
         case (segment % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 85;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 85;
            end
            default: begin
               sender_idle_pct    = 7;
               receiver_stall_pct = 7;
            end
         endcase
         repeat (24) offer_param(random_param());
      end

      // The receiver holds off while t values keep coming, so that the block
      // fills up; then the sender waits for every word before going on.
      write_point_count(4'd8);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_request       = 1'b1;
      repeat (16) offer_param(random_param());
      drain_results();
      receiver_stall_pct = 30;
      repeat (8) offer_param(random_param());

      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
